// ===== hdl/circular_double_ended_queue_assert.svh =====
// assertion macros used by the deque controller
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CDQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cdq_pkg.sv =====
// types and constants of the circular deque
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // memory port command from the controller
    typedef struct packed {
        logic we;
        logic re;
    } mem_cmd_t;

    // result stage contents handed to the top level
    typedef struct packed {
        logic             valid;
        status_t          status;
        logic             pop_ok;
        logic [OCC_W-1:0] occupancy;
    } rsp_ctl_t;

endpackage

// ===== hdl/cdq_req_if.sv =====
// request channel: operation and value
interface cdq_req_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

// ===== hdl/cdq_rsp_if.sv =====
// response channel: status, popped value and occupancy
interface cdq_rsp_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] popped_value;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output popped_value, output occupancy,
                    input ready);
    modport sink (input valid, input status, input popped_value, input occupancy,
                  output ready);
endinterface

// ===== hdl/cdq_mem.sv =====
// slot storage: single-port synchronous ram with a registered read
module cdq_mem #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  cdq_pkg::mem_cmd_t             cmd,
    input  logic [AW-1:0]                 addr,
    input  logic [cdq_pkg::DATA_W-1:0]    wdata,
    output logic [cdq_pkg::DATA_W-1:0]    rdata
);
    import cdq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[addr] <= wdata;
        end
        // read data holds until the next read
        if (cmd.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/cdq_ctrl.sv =====
// deque pointers, occupancy, operation decode and result stage
module cdq_ctrl #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic [cdq_pkg::OP_W-1:0]   req_operation,
    output logic                       req_ready,
    input  logic                       rsp_ready,
    output cdq_pkg::mem_cmd_t          mem_cmd,
    output logic [AW-1:0]              mem_addr,
    output cdq_pkg::rsp_ctl_t          rsp_ctl
);
    import cdq_pkg::*;
    `include "circular_double_ended_queue_assert.svh"

    localparam int CNT_W = ($clog2(DEPTH + 1) > OCC_W) ? $clog2(DEPTH + 1) : OCC_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             valid_reg;
    status_t          status_reg, status_next;
    logic             pop_ok_reg, pop_ok_next;
    logic [OCC_W-1:0] occ_reg;

    op_t           op;
    logic          accept;
    logic          full;
    logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;

    assign op       = op_t'(req_operation);
    assign req_ready = !valid_reg || rsp_ready;
    assign accept   = req_valid && req_ready;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
    assign full     = !empty_reg && (tail_inc == head_reg);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        pop_ok_next = 1'b0;
        mem_cmd     = '0;
        mem_addr    = '0;
        if (accept)
        begin
            case (op)
                OP_PUSH_FRONT, OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_cmd.we = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (empty_reg)
                        begin
                            // first entry always lands in slot zero
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b0;
                            mem_addr   = '0;
                        end
                        else if (op == OP_PUSH_FRONT)
                        begin
                            head_next = head_dec;
                            mem_addr  = head_dec;
                        end
                        else
                        begin
                            tail_next = tail_inc;
                            mem_addr  = tail_inc;
                        end
                    end
                end
                OP_POP_FRONT, OP_POP_REAR:
                begin
                    if (empty_reg)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        mem_cmd.re  = 1'b1;
                        pop_ok_next = 1'b1;
                        mem_addr    = (op == OP_POP_FRONT) ? head_reg : tail_reg;
                        count_next  = count_reg - 1'b1;
                        if (head_reg == tail_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else if (op == OP_POP_FRONT)
                        begin
                            head_next = head_inc;
                        end
                        else
                        begin
                            tail_next = tail_dec;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            count_reg <= count_next;
            if (req_ready)
            begin
                valid_reg <= req_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
            occ_reg    <= count_next[OCC_W-1:0];
        end
    end

    assign rsp_ctl.valid     = valid_reg;
    assign rsp_ctl.status    = status_reg;
    assign rsp_ctl.pop_ok    = pop_ok_reg;
    assign rsp_ctl.occupancy = occ_reg;

    `CDQ_ASSERT_IMPL(a_empty_ptrs, empty_reg,
        (head_reg == '0) && (tail_reg == '0) && (count_reg == '0),
        "empty deque with nonzero pointers or count")
    `CDQ_ASSERT_IMPL(a_count_range, !empty_reg,
        (count_reg != '0) && (count_reg <= CNT_W'(DEPTH)),
        "occupancy out of range while not empty")
    `CDQ_ASSERT_NEXT(a_push_count, accept && mem_cmd.we,
        count_reg == $past(count_reg) + 1'b1, "successful push did not grow occupancy")
    `CDQ_ASSERT_IMPL(a_pop_status, valid_reg && pop_ok_reg, status_reg == ST_OK,
        "popped data with an error status")
endmodule

// ===== hdl/circular_double_ended_queue.sv =====
// top level of the circular double-ended queue
//
//  channel | dir | fields                                 | beat when
//  req     | in  | operation, value                       | req.valid && req.ready
//  rsp     | out | status, popped_value, occupancy        | rsp.valid && rsp.ready
//
// one beat per cycle while rsp.ready keeps up; a response appears the cycle after its request beat,
// popped data coming straight from the ram read register
// pointers update at the request beat, so a pop reads a slot written the cycle before
// req.ready drops only while a response waits and rsp.ready is low
// reset clears pointers, count and response valid and sets the empty flag; slot contents are not cleared
module circular_double_ended_queue #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    cdq_req_if.sink    req,
    cdq_rsp_if.source  rsp
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    mem_cmd_t          mem_cmd;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_rdata;
    rsp_ctl_t          rsp_ctl;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_operation (req.operation),
        .req_ready     (req.ready),
        .rsp_ready     (rsp.ready),
        .mem_cmd       (mem_cmd),
        .mem_addr      (mem_addr),
        .rsp_ctl       (rsp_ctl)
    );

    cdq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (req.value),
        .rdata (mem_rdata)
    );

    assign rsp.valid        = rsp_ctl.valid;
    assign rsp.status       = rsp_ctl.status;
    assign rsp.popped_value = rsp_ctl.pop_ok ? mem_rdata : '0;
    assign rsp.occupancy    = rsp_ctl.occupancy;
endmodule
